### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define MFQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("MFQ assertion failed");
// Condition must never be seen outside reset.
`define MFQ_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("MFQ forbidden condition seen");
`else
`define MFQ_ASSERT(lbl, clk, rstn, prop)
`define MFQ_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### sv/mfqs_pkg.sv
// ----------------------------------------------------------------------------
// mfqs_pkg
// Shared constants and codes of the multilevel feedback queue scheduler.
// ----------------------------------------------------------------------------
package mfqs_pkg;

  localparam int unsigned MaxJobsDef = 64;
  localparam int unsigned LevelsDef  = 4;
  localparam int unsigned SliceStep  = 500;

  localparam int unsigned IdW     = 6;
  localparam int unsigned RunW    = 15;
  localparam int unsigned GrantW  = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  // Operation codes of an input item.
  typedef enum logic [0:0] {
    OP_ADD      = 1'b0,
    OP_DISPATCH = 1'b1
  } op_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_PARTIAL  = 3'd1,
    ST_FINISHED = 3'd2,
    ST_IDLE     = 3'd3,
    ST_REJECTED = 3'd4
  } status_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_BASE_SLICE   = 2'd0,
    REG_NUM_LEVELS   = 2'd1,
    REG_BOOST_PERIOD = 2'd2
  } cfg_reg_e;

endpackage

### sv/mfqs_ram.sv
// ----------------------------------------------------------------------------
// mfqs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mfqs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### sv/multilevel_feedback_queue_scheduler_core.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler_core
// Multilevel feedback queue scheduler with queue rings held in RAM.
// ----------------------------------------------------------------------------
// Usage: an input item is accepted when in_valid_i is high and in_stall_o is
// low. An add item (operation 0) puts a job at the tail of the top queue; a
// dispatch item (operation 1) serves one round. Each item gives exactly one
// result item on the output channel, held in an output register until
// out_stall_i is low. A new item is taken only once the previous result has
// left the output register.
// Sequence: an add gives its result straight from the idle state. A dispatch
// goes through search with queue RAM read, run-time RAM read and update.
// When boosting is on and the round count is non-zero, a bit-serial modulo
// of the 32-bit round count by the boost period comes first; if the remainder
// is zero, a boost then moves each job of each lower level to the top queue.
// Reset clears all queues, counters, time and the per-job flags; the RAMs
// need no clearing pass. Configuration writes take effect at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multilevel_feedback_queue_scheduler_core #(
  parameter int unsigned MAX_JOBS = mfqs_pkg::MaxJobsDef,
  parameter int unsigned LEVELS   = mfqs_pkg::LevelsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic [mfqs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mfqs_pkg::CfgW-1:0]    cfg_wdata_i,
  // Input channel.
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         operation_i,
  input  logic [mfqs_pkg::IdW-1:0]     job_id_i,
  input  logic [mfqs_pkg::RunW-1:0]    run_length_i,
  // Output channel.
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   status_o,
  output logic [mfqs_pkg::IdW-1:0]     served_id_o,
  output logic [1:0]                   served_level_o,
  output logic [mfqs_pkg::GrantW-1:0]  granted_time_o,
  output logic [mfqs_pkg::TimeW-1:0]   start_time_o,
  output logic [mfqs_pkg::TimeW-1:0]   end_time_o,
  output logic                         first_run_o,
  output logic                         boosted_o
);

  localparam int unsigned IdxW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_JOBS + 1);
  localparam int unsigned LvW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned BlW   = $clog2(LEVELS + 1);
  localparam int unsigned SDep  = LEVELS * MAX_JOBS;
  localparam int unsigned SAW   = $clog2(SDep);
  localparam int unsigned IdW   = mfqs_pkg::IdW;
  localparam int unsigned RunW  = mfqs_pkg::RunW;
  localparam int unsigned TimeW = mfqs_pkg::TimeW;

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_BOOST, S_BWR, S_FIND, S_RID, S_RREM
  } state_e;

  // Configuration registers.
  logic [14:0] base_slice_q;
  logic [2:0]  num_levels_q;
  logic [15:0] boost_period_q;

  // Control and scheduler state.
  state_e                 state_q;
  logic [IdxW-1:0]        head_q [LEVELS];
  logic [CntW-1:0]        count_q [LEVELS];
  logic [MAX_JOBS-1:0]    has_run_q;
  logic [MAX_JOBS-1:0]    queued_q;
  logic [CntW-1:0]        pending_q;
  logic [TimeW-1:0]       time_q;
  logic [31:0]            round_q;
  logic                   bst_q;
  logic [BlW-1:0]         blvl_q;
  logic [LvW-1:0]         found_q;
  logic [IdxW-1:0]        job_q;
  logic [15:0]            mrem_q;
  logic [31:0]            msh_q;
  logic [5:0]             mcnt_q;

  // Output register.
  logic                   out_valid_q;
  logic [2:0]             status_q;
  logic [IdW-1:0]         sid_q;
  logic [1:0]             slvl_q;
  logic [15:0]            grant_q;
  logic [TimeW-1:0]       t0_q;
  logic [TimeW-1:0]       t1_q;
  logic                   first_q;
  logic                   bsto_q;

  // RAM ports.
  logic            st_we;
  logic [SAW-1:0]  st_waddr;
  logic [SAW-1:0]  st_raddr;
  logic [IdW-1:0]  st_wdata;
  logic [IdW-1:0]  st_rdata;
  logic            rt_we;
  logic [IdxW-1:0] rt_waddr;
  logic [IdxW-1:0] rt_raddr;
  logic [RunW-1:0] rt_wdata;
  logic [RunW-1:0] rt_rdata;

  // Search, slice and tail helpers.
  logic            any_found;
  logic [LvW-1:0]  first_lvl;
  logic [2:0]      eff_lvls;
  logic [LvW-1:0]  next_lvl;
  logic [15:0]     slice;
  logic            in_acc;
  logic            add_ok;
  logic [IdxW-1:0] in_idx;
  logic [LvW-1:0]  bl_idx;
  logic [16:0]     mod_try;
  logic            rem_gt;

  function automatic logic [IdxW-1:0] ring_pos(input logic [IdxW-1:0] h,
                                               input logic [CntW-1:0] c);
    logic [CntW:0] s;
    s = (CntW+1)'(h) + (CntW+1)'(c);
    if (s >= (CntW+1)'(MAX_JOBS)) begin
      s = s - (CntW+1)'(MAX_JOBS);
    end
    return IdxW'(s);
  endfunction

  function automatic logic [IdxW-1:0] ring_inc(input logic [IdxW-1:0] h);
    logic [IdxW:0] s;
    s = (IdxW+1)'(h) + (IdxW+1)'(1);
    if (s >= (IdxW+1)'(MAX_JOBS)) begin
      s = '0;
    end
    return IdxW'(s);
  endfunction

  function automatic logic [SAW-1:0] st_addr(input logic [LvW-1:0] l,
                                             input logic [IdxW-1:0] p);
    return SAW'(SAW'(l) * SAW'(MAX_JOBS) + SAW'(p));
  endfunction

  // Handshake and input decode.
  assign in_stall_o = (state_q != S_IDLE) | out_valid_q;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign in_idx     = IdxW'(job_id_i);
  assign add_ok     = (32'(job_id_i) < 32'(MAX_JOBS)) && !queued_q[in_idx] &&
                      (pending_q != CntW'(MAX_JOBS));
  assign bl_idx     = blvl_q[LvW-1:0];
  assign mod_try    = {mrem_q, msh_q[31]};

  // Highest non-empty level.
  always_comb begin
    any_found = 1'b0;
    first_lvl = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (count_q[l] != '0) begin
        any_found = 1'b1;
        first_lvl = LvW'(l);
      end
    end
  end

  // Slice of the served level and the level an unfinished job goes to.
  always_comb begin
    eff_lvls = num_levels_q;
    if (eff_lvls == 3'd0) begin
      eff_lvls = 3'd1;
    end
    if (32'(eff_lvls) > 32'(LEVELS)) begin
      eff_lvls = 3'(LEVELS);
    end
    slice    = 16'(base_slice_q) + 16'(16'(found_q) * 16'(mfqs_pkg::SliceStep));
    rem_gt   = 16'(rt_rdata) > slice;
    next_lvl = found_q;
    if (32'(found_q) + 32'd1 < 32'(eff_lvls)) begin
      next_lvl = LvW'(32'(found_q) + 32'd1);
    end
  end

  // RAM access control.
  always_comb begin
    st_we    = 1'b0;
    st_waddr = '0;
    st_wdata = '0;
    st_raddr = '0;
    rt_we    = 1'b0;
    rt_waddr = '0;
    rt_wdata = '0;
    rt_raddr = job_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && operation_i == mfqs_pkg::OP_ADD && add_ok) begin
          st_we    = 1'b1;
          st_waddr = st_addr('0, ring_pos(head_q[0], count_q[0]));
          st_wdata = job_id_i;
          rt_we    = 1'b1;
          rt_waddr = in_idx;
          rt_wdata = run_length_i;
        end
      end
      S_BOOST: begin
        st_raddr = st_addr(bl_idx, head_q[bl_idx]);
      end
      S_BWR: begin
        st_we    = 1'b1;
        st_waddr = st_addr('0, ring_pos(head_q[0], count_q[0]));
        st_wdata = st_rdata;
      end
      S_FIND: begin
        st_raddr = st_addr(first_lvl, head_q[first_lvl]);
      end
      S_RID: begin
        rt_raddr = IdxW'(st_rdata);
      end
      S_RREM: begin
        rt_we    = 1'b1;
        rt_waddr = job_q;
        rt_wdata = rem_gt ? RunW'(16'(rt_rdata) - slice) : '0;
        if (rem_gt) begin
          st_we    = 1'b1;
          st_waddr = st_addr(next_lvl, ring_pos(head_q[next_lvl], count_q[next_lvl]));
          st_wdata = IdW'(job_q);
        end
      end
      default: begin
      end
    endcase
  end

  // Queue ring store, one ring of MAX_JOBS ids per level.
  mfqs_ram #(.Width(IdW), .Depth(SDep)) u_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  // Remaining run time per job.
  mfqs_ram #(.Width(RunW), .Depth(MAX_JOBS)) u_remain (
    .clk_i  (clk_i),
    .we_i   (rt_we),
    .waddr_i(rt_waddr),
    .wdata_i(rt_wdata),
    .raddr_i(rt_raddr),
    .rdata_o(rt_rdata)
  );

  // Sequencer, scheduler state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_slice_q   <= 15'd1000;
      num_levels_q   <= 3'd4;
      boost_period_q <= '0;
      state_q        <= S_IDLE;
      for (int l = 0; l < LEVELS; l++) begin
        head_q[l]  <= '0;
        count_q[l] <= '0;
      end
      has_run_q   <= '0;
      queued_q    <= '0;
      pending_q   <= '0;
      time_q      <= '0;
      round_q     <= '0;
      bst_q       <= 1'b0;
      blvl_q      <= '0;
      found_q     <= '0;
      job_q       <= '0;
      mrem_q      <= '0;
      msh_q       <= '0;
      mcnt_q      <= '0;
      out_valid_q <= 1'b0;
      status_q    <= '0;
      sid_q       <= '0;
      slvl_q      <= '0;
      grant_q     <= '0;
      t0_q        <= '0;
      t1_q        <= '0;
      first_q     <= 1'b0;
      bsto_q      <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mfqs_pkg::REG_BASE_SLICE:   base_slice_q   <= cfg_wdata_i[14:0];
          mfqs_pkg::REG_NUM_LEVELS:   num_levels_q   <= cfg_wdata_i[2:0];
          mfqs_pkg::REG_BOOST_PERIOD: boost_period_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (operation_i == mfqs_pkg::OP_ADD) begin
              out_valid_q <= 1'b1;
              sid_q       <= job_id_i;
              slvl_q      <= '0;
              grant_q     <= '0;
              t0_q        <= time_q;
              t1_q        <= time_q;
              first_q     <= 1'b0;
              bsto_q      <= 1'b0;
              if (add_ok) begin
                status_q           <= mfqs_pkg::ST_ADDED;
                has_run_q[in_idx]  <= 1'b0;
                queued_q[in_idx]   <= 1'b1;
                pending_q          <= pending_q + 1'b1;
                count_q[0]         <= count_q[0] + 1'b1;
              end else begin
                status_q <= mfqs_pkg::ST_REJECTED;
              end
            end else begin
              bst_q  <= 1'b0;
              blvl_q <= BlW'(1);
              if (boost_period_q != '0 && round_q != '0) begin
                mrem_q  <= '0;
                msh_q   <= round_q;
                mcnt_q  <= '0;
                state_q <= S_MOD;
              end else begin
                state_q <= S_FIND;
              end
            end
          end
        end
        // Bit-serial remainder of the round count by the boost period.
        S_MOD: begin
          if (mod_try >= {1'b0, boost_period_q}) begin
            mrem_q <= 16'(mod_try - {1'b0, boost_period_q});
          end else begin
            mrem_q <= 16'(mod_try);
          end
          msh_q  <= {msh_q[30:0], 1'b0};
          mcnt_q <= mcnt_q + 1'b1;
          if (mcnt_q == 6'd31) begin
            if (mod_try == {1'b0, boost_period_q} || mod_try == '0) begin
              bst_q   <= 1'b1;
              state_q <= S_BOOST;
            end else begin
              state_q <= S_FIND;
            end
          end
        end
        // Move every lower queue, one job at a time, to the top queue.
        S_BOOST: begin
          if (32'(blvl_q) >= 32'(LEVELS)) begin
            state_q <= S_FIND;
          end else if (count_q[bl_idx] == '0) begin
            blvl_q <= blvl_q + 1'b1;
          end else begin
            state_q <= S_BWR;
          end
        end
        S_BWR: begin
          head_q[bl_idx]  <= ring_inc(head_q[bl_idx]);
          count_q[bl_idx] <= count_q[bl_idx] - 1'b1;
          count_q[0]      <= count_q[0] + 1'b1;
          state_q         <= S_BOOST;
        end
        // Pick the highest non-empty level and pop its head.
        S_FIND: begin
          round_q <= round_q + 1'b1;
          if (!any_found) begin
            out_valid_q <= 1'b1;
            status_q    <= mfqs_pkg::ST_IDLE;
            sid_q       <= '0;
            slvl_q      <= '0;
            grant_q     <= '0;
            t0_q        <= time_q;
            t1_q        <= time_q;
            first_q     <= 1'b0;
            bsto_q      <= bst_q;
            state_q     <= S_IDLE;
          end else begin
            found_q            <= first_lvl;
            head_q[first_lvl]  <= ring_inc(head_q[first_lvl]);
            count_q[first_lvl] <= count_q[first_lvl] - 1'b1;
            state_q            <= S_RID;
          end
        end
        S_RID: begin
          job_q   <= IdxW'(st_rdata);
          state_q <= S_RREM;
        end
        // Run the job for its slice or to its end.
        S_RREM: begin
          out_valid_q      <= 1'b1;
          sid_q            <= IdW'(job_q);
          slvl_q           <= 2'(found_q);
          t0_q             <= time_q;
          first_q          <= ~has_run_q[job_q];
          bsto_q           <= bst_q;
          has_run_q[job_q] <= 1'b1;
          if (rem_gt) begin
            status_q          <= mfqs_pkg::ST_PARTIAL;
            grant_q           <= slice;
            time_q            <= time_q + TimeW'(slice);
            t1_q              <= time_q + TimeW'(slice);
            count_q[next_lvl] <= count_q[next_lvl] + 1'b1;
          end else begin
            status_q        <= mfqs_pkg::ST_FINISHED;
            grant_q         <= 16'(rt_rdata);
            time_q          <= time_q + TimeW'(rt_rdata);
            t1_q            <= time_q + TimeW'(rt_rdata);
            queued_q[job_q] <= 1'b0;
            pending_q       <= pending_q - 1'b1;
          end
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign served_id_o    = sid_q;
  assign served_level_o = slvl_q;
  assign granted_time_o = grant_q;
  assign start_time_o   = t0_q;
  assign end_time_o     = t1_q;
  assign first_run_o    = first_q;
  assign boosted_o      = bsto_q;

  // Consistency checks.
  logic [CntW+3:0] count_sum;
  logic            counts_ok;
  always_comb begin
    count_sum = '0;
    for (int l = 0; l < LEVELS; l++) begin
      count_sum = count_sum + (CntW+4)'(count_q[l]);
    end
  end
  assign counts_ok = (count_sum == (CntW+4)'(pending_q));

  `MFQ_NEVER(a_pending_bound, clk_i, rst_ni, 32'(pending_q) > 32'(MAX_JOBS))
  `MFQ_ASSERT(a_counts_match, clk_i, rst_ni, (state_q == S_IDLE) |-> counts_ok)
  `MFQ_ASSERT(a_boost_enabled, clk_i, rst_ni, (state_q == S_MOD) |-> (boost_period_q != '0))
  `MFQ_ASSERT(a_done_to_out, clk_i, rst_ni, (state_q == S_RREM) |=> (out_valid_q && state_q == S_IDLE))

endmodule
